/* rtl/core/cqpw_pkg.sv */
// ----------------------------------------------------------------------------
// cqpw_pkg
// Shared codes, widths and result layout of the completion queue core.
// ----------------------------------------------------------------------------
`default_nettype none

package cqpw_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 64;
   localparam int POLL_MAX_DEFAULT    = 256;
   localparam int DRAIN_MAX_DEFAULT   = 32;

   localparam int FIELDS_W = 42;
   localparam int SEQ_W    = 64;
   localparam int ENTRY_W  = FIELDS_W + SEQ_W;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_QUEUE_CAPACITY = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_LIMIT     = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRAIN_LIMIT    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_METRICS_ENABLE = 8'd3;

   typedef enum logic [2:0] {
      REQ_START_POLL = 3'd0,
      REQ_PUBLISH    = 3'd1,
      REQ_END_POLL   = 3'd2,
      REQ_DRAIN      = 3'd3,
      REQ_SHUTDOWN   = 3'd4,
      REQ_QUERY      = 3'd5
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_SUCCEEDED = 2'd0,
      KIND_CANCELLED = 2'd1,
      KIND_PACKET    = 2'd2,
      KIND_FAILED    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_STOPPING  = 3'd1,
      STATUS_STALE     = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_EXHAUSTED = 3'd4,
      STATUS_INVALID   = 3'd5,
      STATUS_CANCELLED = 3'd6,
      STATUS_BUSY      = 3'd7
   } status_type;

   typedef struct packed {
      status_type  status;
      logic        item_valid;
      logic [1:0]  kind;
      logic [15:0] connection;
      logic [7:0]  channel;
      logic [15:0] payload;
      logic [63:0] tag;
      logic [5:0]  drained;
      logic [6:0]  queue_level;
      logic [6:0]  inbound_level;
      logic [63:0] drop_count;
      logic        last;
   } rsp_fields_type;

endpackage

`default_nettype wire

/* rtl/core/cqpw_req_if.sv */
// ----------------------------------------------------------------------------
// cqpw_req_if
// Request channel of the completion queue: valid, ready and request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface cqpw_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [8:0]  count_limit;
   logic [63:0] poll_tag;
   logic        cancel_requested;
   logic [1:0]  item_kind;
   logic [15:0] connection_id;
   logic [7:0]  channel_id;
   logic [15:0] payload_handle;

   modport source (
      output valid, req_type, count_limit, poll_tag, cancel_requested,
             item_kind, connection_id, channel_id, payload_handle,
      input  ready
   );

   modport sink (
      input  valid, req_type, count_limit, poll_tag, cancel_requested,
             item_kind, connection_id, channel_id, payload_handle,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/core/cqpw_rsp_if.sv */
// ----------------------------------------------------------------------------
// cqpw_rsp_if
// Result channel of the completion queue: valid, ready and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface cqpw_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        item_valid;
   logic [1:0]  out_kind;
   logic [15:0] out_connection;
   logic [7:0]  out_channel;
   logic [15:0] out_payload;
   logic [63:0] out_tag;
   logic [5:0]  drained_count;
   logic [6:0]  queue_level;
   logic [6:0]  inbound_level;
   logic [63:0] drop_count;
   logic        last;

   modport source (
      output valid, status, item_valid, out_kind, out_connection, out_channel,
             out_payload, out_tag, drained_count, queue_level, inbound_level,
             drop_count, last,
      input  ready
   );

   modport sink (
      input  valid, status, item_valid, out_kind, out_connection, out_channel,
             out_payload, out_tag, drained_count, queue_level, inbound_level,
             drop_count, last,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/core/cqpw_csr_if.sv */
// ----------------------------------------------------------------------------
// cqpw_csr_if
// Register write channel of the completion queue: valid, ready, index, data.
// ----------------------------------------------------------------------------
`default_nettype none

interface cqpw_csr_if;
   logic                               valid;
   logic                               ready;
   logic [cqpw_pkg::CSR_INDEX_W-1:0]   index;
   logic [cqpw_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/cqpw_ram.sv */
// ----------------------------------------------------------------------------
// cqpw_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cqpw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/completion_queue_with_poll_window_core.sv */
// ----------------------------------------------------------------------------
// completion_queue_with_poll_window_core
// Ring of completion records admitted inside a budgeted poll window.
// ----------------------------------------------------------------------------
// A request is taken into an input register in the cycle it is offered while
// the core is idle, and is executed in the following cycle once the output
// register is free. A drain emits its records oldest first, each read through
// the registered read port of the ring memory before it is emitted, and takes
// no new request until its last record; an empty or refused drain gives a
// single result. Ring entries are never cleared, so there is no clearing
// pass after reset.
`default_nettype none

module completion_queue_with_poll_window_core #(
   parameter int QUEUE_DEPTH = cqpw_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int POLL_MAX    = cqpw_pkg::POLL_MAX_DEFAULT,
   parameter int DRAIN_MAX   = cqpw_pkg::DRAIN_MAX_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   cqpw_req_if.sink   req_ch,
   cqpw_rsp_if.source rsp_ch,
   cqpw_csr_if.sink   csr_ch
);

   import cqpw_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW    = (IDX_W + 1 > 7) ? IDX_W + 1 : 7;

   localparam logic [6:0] CAP_TOP   = 7'((QUEUE_DEPTH < 127) ? QUEUE_DEPTH : 127);
   localparam logic [8:0] POLL_TOP  = 9'((POLL_MAX < 511) ? POLL_MAX : 511);
   localparam logic [5:0] DRAIN_TOP = 6'((DRAIN_MAX < 63) ? DRAIN_MAX : 63);

   localparam logic [6:0] CAP_RESET   = (CAP_TOP < 7'd64) ? CAP_TOP : 7'd64;
   localparam logic [8:0] POLL_RESET  = (POLL_TOP < 9'd256) ? POLL_TOP : 9'd256;
   localparam logic [5:0] DRAIN_RESET = (DRAIN_TOP < 6'd32) ? DRAIN_TOP : 6'd32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DRAIN_RD,
      ST_DRAIN_DATA
   } state_type;

   state_type      state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   rsp_fields_type out_ff, out_in;

   logic [IDX_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [6:0]       fill_ff, fill_in, inbound_ff, inbound_in;
   logic [63:0]      seq_ff, seq_in, gen_ff, gen_in, refused_ff, refused_in;
   logic [8:0]       budget_ff, budget_in;
   logic             window_ff, window_in, stopping_ff, stopping_in;
   logic [5:0]       drained_ff, drained_in;

   logic [6:0]       cap_ff, cap_in;
   logic [8:0]       poll_lim_ff, poll_lim_in;
   logic [5:0]       drain_lim_ff, drain_lim_in;
   logic             metrics_ff, metrics_in;

   logic [2:0]  req_type_ff;
   logic [8:0]  req_count_ff;
   logic [63:0] req_tag_ff;
   logic        req_cancel_ff;
   logic [1:0]  req_kind_ff;
   logic [15:0] req_conn_ff;
   logic [7:0]  req_chan_ff;
   logic [15:0] req_pay_ff;

   logic               req_accept;
   logic               out_free;
   logic               ram_we, ram_re;
   logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;

   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                input logic [6:0] cap);
      logic [CW-1:0] nxt;
      nxt = CW'(idx) + CW'(1);
      return (nxt >= CW'(cap)) ? '0 : nxt[IDX_W-1:0];
   endfunction

   assign req_accept    = req_ch.valid && (state_ff == ST_IDLE);
   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign csr_ch.ready  = 1'b1;
   assign out_free      = !out_valid_ff || rsp_ch.ready;

   cqpw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      logic       simple;
      logic       report_drop;
      logic       packet;
      logic       rd_last;
      logic [5:0] rd_n;
      status_type status_v;
      logic [63:0] tag_v;

      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_in       = out_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      inbound_in   = inbound_ff;
      seq_in       = seq_ff;
      gen_in       = gen_ff;
      refused_in   = refused_ff;
      budget_in    = budget_ff;
      window_in    = window_ff;
      stopping_in  = stopping_ff;
      drained_in   = drained_ff;
      cap_in       = cap_ff;
      poll_lim_in  = poll_lim_ff;
      drain_lim_in = drain_lim_ff;
      metrics_in   = metrics_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      simple       = 1'b0;
      report_drop  = 1'b0;
      status_v     = STATUS_OK;
      tag_v        = '0;
      rd_last      = 1'b0;
      rd_n         = '0;
      packet       = (req_kind_ff == KIND_PACKET);
      ram_wr_data  = {seq_ff, (packet ? req_pay_ff : 16'd0),
                      (packet ? req_chan_ff : 8'd0), req_conn_ff, req_kind_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               simple   = 1'b1;
               state_in = ST_IDLE;
               unique case (req_type_ff)
                  REQ_START_POLL: begin
                     if (req_count_ff == '0 || req_count_ff > poll_lim_ff)
                        status_v = STATUS_INVALID;
                     else if (req_cancel_ff) status_v = STATUS_CANCELLED;
                     else if (stopping_ff) status_v = STATUS_STOPPING;
                     else if (window_ff) status_v = STATUS_BUSY;
                     else if (gen_ff == '1) status_v = STATUS_EXHAUSTED;
                     else begin
                        gen_in    = gen_ff + 64'd1;
                        budget_in = req_count_ff;
                        window_in = 1'b1;
                        tag_v     = gen_ff + 64'd1;
                     end
                  end
                  REQ_PUBLISH: begin
                     if (req_conn_ff == '0 || (packet && req_pay_ff == '0))
                        status_v = STATUS_INVALID;
                     else if (stopping_ff) status_v = STATUS_STOPPING;
                     else if (!window_ff || req_tag_ff != gen_ff)
                        status_v = STATUS_STALE;
                     else if (budget_ff == '0 || fill_ff >= cap_ff) begin
                        status_v = STATUS_FULL;
                        if (metrics_ff && refused_ff != '1)
                           refused_in = refused_ff + 64'd1;
                     end
                     else if (seq_ff == '0 || seq_ff == '1)
                        status_v = STATUS_EXHAUSTED;
                     else begin
                        ram_we    = 1'b1;
                        seq_in    = seq_ff + 64'd1;
                        tail_in   = advance(tail_ff, cap_ff);
                        fill_in   = fill_ff + 7'd1;
                        budget_in = budget_ff - 9'd1;
                        if (packet) inbound_in = inbound_ff + 7'd1;
                     end
                  end
                  REQ_END_POLL: begin
                     window_in = 1'b0;
                     budget_in = '0;
                  end
                  REQ_DRAIN: begin
                     if (req_count_ff == '0 || req_count_ff > {3'd0, drain_lim_ff})
                        status_v = STATUS_INVALID;
                     else if (stopping_ff) status_v = STATUS_STOPPING;
                     else if (fill_ff == '0) report_drop = 1'b1;
                     else begin
                        simple     = 1'b0;
                        ram_re     = 1'b1;
                        drained_in = '0;
                        state_in   = ST_DRAIN_DATA;
                     end
                  end
                  REQ_SHUTDOWN: begin
                     if (!stopping_ff) begin
                        stopping_in = 1'b1;
                        window_in   = 1'b0;
                        budget_in   = '0;
                        head_in     = '0;
                        tail_in     = '0;
                        fill_in     = '0;
                        inbound_in  = '0;
                     end
                  end
                  REQ_QUERY: begin
                     status_v = STATUS_OK;
                  end
                  default: begin
                     status_v = STATUS_INVALID;
                  end
               endcase
            end
         end
         ST_DRAIN_RD: begin
            if (out_free) begin
               ram_re   = 1'b1;
               state_in = ST_DRAIN_DATA;
            end
         end
         ST_DRAIN_DATA: begin
            rd_n       = drained_ff + 6'd1;
            drained_in = rd_n;
            head_in    = advance(head_ff, cap_ff);
            fill_in    = fill_ff - 7'd1;
            if (ram_rd_data[1:0] == KIND_PACKET && inbound_ff != '0)
               inbound_in = inbound_ff - 7'd1;
            rd_last = ({3'd0, rd_n} == req_count_ff) || (fill_in == '0);
            out_in               = '0;
            out_in.status        = STATUS_OK;
            out_in.item_valid    = 1'b1;
            out_in.kind          = ram_rd_data[1:0];
            out_in.connection    = ram_rd_data[17:2];
            out_in.channel       = ram_rd_data[25:18];
            out_in.payload       = ram_rd_data[41:26];
            out_in.tag           = ram_rd_data[ENTRY_W-1:FIELDS_W];
            out_in.drained       = rd_n;
            out_in.queue_level   = fill_in;
            out_in.inbound_level = inbound_in;
            out_in.last          = rd_last;
            out_valid_in         = 1'b1;
            report_drop          = rd_last;
            state_in             = rd_last ? ST_IDLE : ST_DRAIN_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (simple) begin
         out_in               = '0;
         out_in.status        = status_v;
         out_in.tag           = tag_v;
         out_in.queue_level   = fill_in;
         out_in.inbound_level = inbound_in;
         out_in.last          = 1'b1;
         out_valid_in         = 1'b1;
      end

      if (report_drop && metrics_ff) begin
         out_in.drop_count = refused_ff;
         refused_in        = '0;
      end

      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_QUEUE_CAPACITY: begin
               if (csr_ch.data[6:0] == '0) cap_in = 7'd1;
               else if (csr_ch.data[6:0] > CAP_TOP) cap_in = CAP_TOP;
               else cap_in = csr_ch.data[6:0];
               head_in    = '0;
               tail_in    = '0;
               fill_in    = '0;
               inbound_in = '0;
            end
            CSR_POLL_LIMIT: begin
               if (csr_ch.data == '0) poll_lim_in = 9'd1;
               else if (csr_ch.data > POLL_TOP) poll_lim_in = POLL_TOP;
               else poll_lim_in = csr_ch.data;
            end
            CSR_DRAIN_LIMIT: begin
               if (csr_ch.data[5:0] == '0) drain_lim_in = 6'd1;
               else if (csr_ch.data[5:0] > DRAIN_TOP) drain_lim_in = DRAIN_TOP;
               else drain_lim_in = csr_ch.data[5:0];
            end
            CSR_METRICS_ENABLE: begin
               metrics_in = csr_ch.data[0];
            end
            default: begin
               metrics_in = metrics_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         inbound_ff   <= '0;
         seq_ff       <= 64'd1;
         gen_ff       <= '0;
         refused_ff   <= '0;
         budget_ff    <= '0;
         window_ff    <= 1'b0;
         stopping_ff  <= 1'b0;
         drained_ff   <= '0;
         cap_ff       <= CAP_RESET;
         poll_lim_ff  <= POLL_RESET;
         drain_lim_ff <= DRAIN_RESET;
         metrics_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         inbound_ff   <= inbound_in;
         seq_ff       <= seq_in;
         gen_ff       <= gen_in;
         refused_ff   <= refused_in;
         budget_ff    <= budget_in;
         window_ff    <= window_in;
         stopping_ff  <= stopping_in;
         drained_ff   <= drained_in;
         cap_ff       <= cap_in;
         poll_lim_ff  <= poll_lim_in;
         drain_lim_ff <= drain_lim_in;
         metrics_ff   <= metrics_in;
      end
      out_ff <= out_in;
      if (req_accept) begin
         req_type_ff   <= req_ch.req_type;
         req_count_ff  <= req_ch.count_limit;
         req_tag_ff    <= req_ch.poll_tag;
         req_cancel_ff <= req_ch.cancel_requested;
         req_kind_ff   <= req_ch.item_kind;
         req_conn_ff   <= req_ch.connection_id;
         req_chan_ff   <= req_ch.channel_id;
         req_pay_ff    <= req_ch.payload_handle;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.status         = out_ff.status;
   assign rsp_ch.item_valid     = out_ff.item_valid;
   assign rsp_ch.out_kind       = out_ff.kind;
   assign rsp_ch.out_connection = out_ff.connection;
   assign rsp_ch.out_channel    = out_ff.channel;
   assign rsp_ch.out_payload    = out_ff.payload;
   assign rsp_ch.out_tag        = out_ff.tag;
   assign rsp_ch.drained_count  = out_ff.drained;
   assign rsp_ch.queue_level    = out_ff.queue_level;
   assign rsp_ch.inbound_level  = out_ff.inbound_level;
   assign rsp_ch.drop_count     = out_ff.drop_count;
   assign rsp_ch.last           = out_ff.last;

endmodule

`default_nettype wire

/* tb/tb_completion_queue_with_poll_window_core.sv */
// ----------------------------------------------------------------------------
// tb_completion_queue_with_poll_window_core
// Self-checking bench for the completion queue core. A directed opening walks
// the refusal paths of poll, publish and drain, then randomised phases under
// different register settings mix well-formed poll windows with noise, with
// random request gaps and result back-pressure, and one long result stall. A
// scoreboard class predicts every result transaction and checks it in order.
// ----------------------------------------------------------------------------
module tb_completion_queue_with_poll_window_core;
   import cqpw_pkg::*;

   localparam int CYCLE_LIMIT     = 500000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int SETTLE_CYCLES   = 10;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 37;

   typedef struct {
      logic [2:0]  req_type;
      logic [8:0]  count;
      logic [63:0] tag;
      logic        cancel;
      logic [1:0]  kind;
      logic [15:0] conn;
      logic [7:0]  chan;
      logic [15:0] pay;
   } request_type;

   typedef struct {
      kind_type    kind;
      bit [15:0]   conn;
      bit [7:0]    chan;
      bit [15:0]   pay;
      bit [63:0]   seq;
   } ring_entry_type;

   class completion_ring_model;
      ring_entry_type ring [QUEUE_DEPTH_DEFAULT];
      int unsigned    head, tail, fill, inbound, budget;
      bit [63:0]      next_seq = 1;
      bit [63:0]      generation;
      bit [63:0]      refused;
      bit             window_open, stopping;
      int unsigned    capacity  = QUEUE_DEPTH_DEFAULT;
      int unsigned    poll_lim  = POLL_MAX_DEFAULT;
      int unsigned    drain_lim = DRAIN_MAX_DEFAULT;
      bit             metrics;
      rsp_fields_type pending_results [$];
      int             failures, requests_noted, results_checked, records_checked;
      bit [7:0]       status_seen;

      function int unsigned saturate(int unsigned v, int unsigned hi);
         if (v < 1) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      function int unsigned advance(int unsigned i);
         return (i + 1 >= capacity) ? 0 : i + 1;
      endfunction

      function void flush_ring();
         head = 0;
         tail = 0;
         fill = 0;
         inbound = 0;
      endfunction

      function rsp_fields_type simple_result(status_type st, bit [63:0] tag);
         rsp_fields_type res;
         res = '0;
         res.status        = st;
         res.tag           = tag;
         res.queue_level   = fill[6:0];
         res.inbound_level = inbound[6:0];
         res.last          = 1'b1;
         return res;
      endfunction

      function void apply_register(logic [7:0] idx, logic [8:0] value);
         case (idx)
            CSR_QUEUE_CAPACITY: begin
               capacity = saturate(value[6:0], QUEUE_DEPTH_DEFAULT);
               flush_ring();
            end
            CSR_POLL_LIMIT:     poll_lim  = saturate(value, POLL_MAX_DEFAULT);
            CSR_DRAIN_LIMIT:    drain_lim = saturate(value[5:0], DRAIN_MAX_DEFAULT);
            CSR_METRICS_ENABLE: metrics   = value[0];
            default: ;
         endcase
      endfunction

      function void note_request(request_type r);
         rsp_fields_type res;
         status_type     st;
         ring_entry_type e;
         int unsigned    n;
         requests_noted++;
         case (r.req_type)
            REQ_START_POLL: begin
               if (r.count == 0 || r.count > poll_lim) st = STATUS_INVALID;
               else if (r.cancel) st = STATUS_CANCELLED;
               else if (stopping) st = STATUS_STOPPING;
               else if (window_open) st = STATUS_BUSY;
               else if (generation == '1) st = STATUS_EXHAUSTED;
               else st = STATUS_OK;
               if (st == STATUS_OK) begin
                  generation++;
                  budget = r.count;
                  window_open = 1'b1;
                  pending_results.push_back(simple_result(STATUS_OK, generation));
               end else begin
                  pending_results.push_back(simple_result(st, '0));
               end
            end
            REQ_PUBLISH: begin
               if (r.conn == 0 || (r.kind == KIND_PACKET && r.pay == 0)) st = STATUS_INVALID;
               else if (stopping) st = STATUS_STOPPING;
               else if (!window_open || r.tag != generation) st = STATUS_STALE;
               else if (budget == 0 || fill >= capacity) begin
                  if (metrics && refused != '1) refused++;
                  st = STATUS_FULL;
               end else if (next_seq == 0 || next_seq == '1) st = STATUS_EXHAUSTED;
               else begin
                  e.kind = kind_type'(r.kind);
                  e.conn = r.conn;
                  e.chan = (r.kind == KIND_PACKET) ? r.chan : '0;
                  e.pay  = (r.kind == KIND_PACKET) ? r.pay : '0;
                  e.seq  = next_seq;
                  next_seq++;
                  ring[tail] = e;
                  if (r.kind == KIND_PACKET) inbound++;
                  tail = advance(tail);
                  fill++;
                  budget--;
                  st = STATUS_OK;
               end
               pending_results.push_back(simple_result(st, '0));
            end
            REQ_END_POLL: begin
               window_open = 1'b0;
               budget = 0;
               pending_results.push_back(simple_result(STATUS_OK, '0));
            end
            REQ_DRAIN: begin
               if (r.count == 0 || r.count > drain_lim) begin
                  pending_results.push_back(simple_result(STATUS_INVALID, '0));
               end else if (stopping) begin
                  pending_results.push_back(simple_result(STATUS_STOPPING, '0));
               end else begin
                  n = 0;
                  while (n < r.count && fill != 0) begin
                     e = ring[head];
                     if (e.kind == KIND_PACKET && inbound != 0) inbound--;
                     head = advance(head);
                     fill--;
                     n++;
                     res = '0;
                     res.status        = STATUS_OK;
                     res.item_valid    = 1'b1;
                     res.kind          = e.kind;
                     res.connection    = e.conn;
                     res.channel       = e.chan;
                     res.payload       = e.pay;
                     res.tag           = e.seq;
                     res.drained       = n[5:0];
                     res.queue_level   = fill[6:0];
                     res.inbound_level = inbound[6:0];
                     pending_results.push_back(res);
                  end
                  if (n == 0) pending_results.push_back(simple_result(STATUS_OK, '0));
                  res = pending_results[pending_results.size() - 1];
                  res.queue_level   = fill[6:0];
                  res.inbound_level = inbound[6:0];
                  res.last          = 1'b1;
                  if (metrics) begin
                     res.drop_count = refused;
                     refused = '0;
                  end
                  pending_results[pending_results.size() - 1] = res;
               end
            end
            REQ_SHUTDOWN: begin
               if (!stopping) begin
                  stopping = 1'b1;
                  window_open = 1'b0;
                  budget = 0;
                  flush_ring();
               end
               pending_results.push_back(simple_result(STATUS_OK, '0));
            end
            REQ_QUERY: pending_results.push_back(simple_result(STATUS_OK, '0));
            default:   pending_results.push_back(simple_result(STATUS_INVALID, '0));
         endcase
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_fields_type got);
         rsp_fields_type want;
         if (pending_results.size() == 0) begin
            $error("result transaction with nothing pending: status %0d", got.status);
            failures++;
            return;
         end
         want = pending_results.pop_front();
         results_checked++;
         if (want.item_valid) records_checked++;
         status_seen[want.status] = 1'b1;
         compare_field("status", want.status, got.status);
         compare_field("item_valid", want.item_valid, got.item_valid);
         compare_field("out_kind", want.kind, got.kind);
         compare_field("out_connection", want.connection, got.connection);
         compare_field("out_channel", want.channel, got.channel);
         compare_field("out_payload", want.payload, got.payload);
         compare_field("out_tag", want.tag, got.tag);
         compare_field("drained_count", want.drained, got.drained);
         compare_field("queue_level", want.queue_level, got.queue_level);
         compare_field("inbound_level", want.inbound_level, got.inbound_level);
         compare_field("drop_count", want.drop_count, got.drop_count);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   req_idle_max = 5;
   int   rsp_idle_max = 5;
   bit   hold_off_pending;
   int   cycle_count;
   int   csr_writes;

   completion_ring_model sb = new();

   cqpw_req_if req_ch ();
   cqpw_rsp_if rsp_ch ();
   cqpw_csr_if csr_ch ();

   completion_queue_with_poll_window_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic request_type make_request(logic [2:0] req_type, logic [8:0] count,
                                                logic [63:0] tag, logic cancel,
                                                logic [1:0] kind, logic [15:0] conn,
                                                logic [7:0] chan, logic [15:0] pay);
      request_type r;
      r.req_type = req_type;
      r.count    = count;
      r.tag      = tag;
      r.cancel   = cancel;
      r.kind     = kind;
      r.conn     = conn;
      r.chan     = chan;
      r.pay      = pay;
      return r;
   endfunction

   task automatic send_request(request_type it);
      int gap;
      gap = $urandom_range(0, req_idle_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.req_type         <= it.req_type;
      req_ch.count_limit      <= it.count;
      req_ch.poll_tag         <= it.tag;
      req_ch.cancel_requested <= it.cancel;
      req_ch.item_kind        <= it.kind;
      req_ch.connection_id    <= it.conn;
      req_ch.channel_id       <= it.chan;
      req_ch.payload_handle   <= it.pay;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      sb.note_request(it);
   endtask

   task automatic write_csr(logic [7:0] idx, logic [8:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) @(posedge clock);
      sb.apply_register(idx, value);
      csr_writes++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   // result side: random stalls, one long hold-off when asked
   initial begin : result_sink
      rsp_fields_type got;
      int             wait_cycles;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            wait_cycles = HOLD_OFF_CYCLES;
         end else begin
            wait_cycles = $urandom_range(0, rsp_idle_max);
         end
         if (wait_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (rsp_ch.valid !== 1'b1) @(posedge clock);
         got.status        = status_type'(rsp_ch.status);
         got.item_valid    = rsp_ch.item_valid;
         got.kind          = rsp_ch.out_kind;
         got.connection    = rsp_ch.out_connection;
         got.channel       = rsp_ch.out_channel;
         got.payload       = rsp_ch.out_payload;
         got.tag           = rsp_ch.out_tag;
         got.drained       = rsp_ch.drained_count;
         got.queue_level   = rsp_ch.queue_level;
         got.inbound_level = rsp_ch.inbound_level;
         got.drop_count    = rsp_ch.drop_count;
         got.last          = rsp_ch.last;
         sb.check_result(got);
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      request_type r;
      int          cap_plan [PHASES];
      int          poll_plan [PHASES];
      int          drain_plan [PHASES];
      int          roll, sub, top;

      reset                   <= 1'b1;
      req_ch.valid            <= 1'b0;
      req_ch.req_type         <= '0;
      req_ch.count_limit      <= '0;
      req_ch.poll_tag         <= '0;
      req_ch.cancel_requested <= 1'b0;
      req_ch.item_kind        <= '0;
      req_ch.connection_id    <= '0;
      req_ch.channel_id       <= '0;
      req_ch.payload_handle   <= '0;
      csr_ch.valid            <= 1'b0;
      csr_ch.index            <= '0;
      csr_ch.data             <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed opening, registers at reset values
      send_request(make_request(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_DRAIN, 1, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_DRAIN, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_PUBLISH, 0, 0, 0, KIND_SUCCEEDED, 1, 0, 0));
      send_request(make_request(REQ_START_POLL, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_START_POLL, 257, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_START_POLL, 256, 0, 1, 0, 0, 0, 0));
      send_request(make_request(REQ_START_POLL, 256, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_START_POLL, 3, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_PUBLISH, 0, sb.generation, 0, KIND_FAILED, 0, 1, 1));
      send_request(make_request(REQ_PUBLISH, 0, sb.generation, 0, KIND_PACKET, 7, 3, 0));
      send_request(make_request(REQ_PUBLISH, 0, '1, 0, KIND_PACKET, 7, 3, 9));
      send_request(make_request(REQ_PUBLISH, 0, sb.generation, 0, KIND_PACKET,
                                16'hffff, 8'hff, 16'hffff));
      send_request(make_request(REQ_PUBLISH, 0, sb.generation, 0, KIND_SUCCEEDED,
                                16'h1234, 8'hff, 16'hffff));
      send_request(make_request(REQ_PUBLISH, 0, sb.generation, 0, KIND_CANCELLED,
                                16'h0001, 8'h5a, 16'h00a5));
      send_request(make_request(3'd6, '1, '1, 1, '1, '1, '1, '1));
      send_request(make_request(3'd7, '1, '1, 1, '1, '1, '1, '1));
      send_request(make_request(REQ_END_POLL, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_PUBLISH, 0, sb.generation, 0, KIND_FAILED, 5, 0, 0));
      send_request(make_request(REQ_DRAIN, 32, 0, 0, 0, 0, 0, 0));

      // smallest settings, metrics on
      wait_idle();
      write_csr(CSR_QUEUE_CAPACITY, 9'd0);
      write_csr(CSR_POLL_LIMIT, 9'd0);
      write_csr(CSR_DRAIN_LIMIT, 9'd0);
      write_csr(CSR_METRICS_ENABLE, 9'd1);
      csr_ch.valid <= 1'b0;
      send_request(make_request(REQ_START_POLL, 2, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_START_POLL, 1, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_PUBLISH, 0, sb.generation, 0, KIND_PACKET, 2, 4, 6));
      send_request(make_request(REQ_PUBLISH, 0, sb.generation, 0, KIND_PACKET, 2, 4, 6));
      send_request(make_request(REQ_DRAIN, 2, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_DRAIN, 1, 0, 0, 0, 0, 0, 0));

      cap_plan   = '{64, 1, 8, 127, 0, 3, 100, 40};
      poll_plan  = '{256, 1, 511, 16, 0, 3, 300, 40};
      drain_plan = '{32, 1, 63, 4, 0, 8, 40, 12};

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         write_csr(CSR_QUEUE_CAPACITY, 9'(cap_plan[phase]));
         write_csr(CSR_POLL_LIMIT, 9'(poll_plan[phase]));
         write_csr(CSR_DRAIN_LIMIT, 9'(drain_plan[phase]));
         write_csr(CSR_METRICS_ENABLE, 9'(phase[0]));
         csr_ch.valid <= 1'b0;
         req_idle_max = (phase == 2 || phase == 5) ? 0 : 5;
         rsp_idle_max = (phase == 5 || phase == 6) ? 0 : 5;
         if (phase == 2) hold_off_pending = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            sub  = $urandom_range(0, 99);
            r = make_request(3'($urandom_range(0, 7)), 9'($urandom_range(0, 511)),
                             {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                             2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                             8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            if (roll < 12 || (!sb.window_open && roll < 30)) begin
               top = (sb.poll_lim < 24) ? sb.poll_lim : 24;
               r.req_type = REQ_START_POLL;
               r.cancel   = ($urandom_range(0, 9) == 0);
               if (sub < 70) r.count = 9'($urandom_range(1, top));
               else if (sub < 90) r.count = 9'($urandom_range(1, sb.poll_lim));
            end else if (roll < 72) begin
               r.req_type = REQ_PUBLISH;
               r.tag      = sb.generation;
               if (r.conn == 0) r.conn = 1;
               if (r.kind == KIND_PACKET && r.pay == 0) r.pay = 1;
            end else if (roll < 87) begin
               r.req_type = REQ_DRAIN;
               if (sub < 90) r.count = 9'($urandom_range(1, sb.drain_lim));
            end else if (roll < 92) begin
               r.req_type = REQ_END_POLL;
            end else if (roll < 94) begin
               r.req_type = REQ_QUERY;
            end else if (r.req_type == REQ_SHUTDOWN) begin
               // shutdown is final, keep it for the closing sequence
               r.req_type = REQ_QUERY;
            end
            send_request(r);
         end
      end

      // shutdown and every request kind after it
      wait_idle();
      req_idle_max = 3;
      rsp_idle_max = 3;
      send_request(make_request(REQ_SHUTDOWN, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_SHUTDOWN, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_START_POLL, 1, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_START_POLL, 1, 0, 1, 0, 0, 0, 0));
      send_request(make_request(REQ_PUBLISH, 0, sb.generation, 0, KIND_PACKET, 3, 3, 3));
      send_request(make_request(REQ_PUBLISH, 0, sb.generation, 0, KIND_PACKET, 0, 3, 3));
      send_request(make_request(REQ_DRAIN, 1, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_DRAIN, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_END_POLL, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(REQ_QUERY, 0, 0, 0, 0, 0, 0, 0));
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests, %0d result transactions, %0d drained records",
               sb.requests_noted, sb.results_checked, sb.records_checked);
      $display("%0d register writes over %0d settings, status codes seen %b, %0d mismatches",
               csr_writes, PHASES + 2, sb.status_seen, sb.failures);
      if (sb.failures == 0 && sb.pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
